// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers. All sample on clk and are off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PBB_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pbb assertion failed");

// Next-cycle implication.
`define PBB_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pbb assertion failed");

`endif

// ===== hw/rtl/pbb_pkg.sv =====
package pbb_pkg;

  localparam int NUM_CLASSES_DEF   = 13;
  localparam int MAX_DIM_DEF       = 4096;

  localparam int LABEL_W           = 8;
  localparam int FRAME_W           = 13;
  localparam int CLASS_IDX_W       = 4;
  localparam int POS_W             = 13;  // box_x, box_y
  localparam int SIZE_W            = 14;  // box_width, box_height

  localparam logic [FRAME_W-1:0] FRAME_WIDTH_RESET = 13'd640;

  // Control that rides along with a pixel down the cell chain.
  typedef struct packed {
    logic valid;
    logic eof;
  } pix_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_DRAIN
  } state_t;

endpackage

// ===== hw/rtl/pbb_cell.sv =====
// One class slot: tracks its box, forwards the pixel, shifts its box on drain.
module pbb_cell #(
  parameter int CLASS_ID = 1,
  parameter int MAX_DIM  = pbb_pkg::MAX_DIM_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pbb_pkg::pix_ctrl_t           ctrl_i,
  input  logic [pbb_pkg::LABEL_W-1:0]  label_i,
  input  logic [$clog2(MAX_DIM)-1:0]   col_i,
  input  logic [$clog2(MAX_DIM)-1:0]   row_i,
  output pbb_pkg::pix_ctrl_t           ctrl_o,
  output logic [pbb_pkg::LABEL_W-1:0]  label_o,
  output logic [$clog2(MAX_DIM)-1:0]   col_o,
  output logic [$clog2(MAX_DIM)-1:0]   row_o,
  input  logic                         shift_i,
  input  logic                         nbr_seen_i,
  input  logic [$clog2(MAX_DIM)-1:0]   nbr_min_col_i,
  input  logic [$clog2(MAX_DIM)-1:0]   nbr_max_col_i,
  input  logic [$clog2(MAX_DIM)-1:0]   nbr_min_row_i,
  input  logic [$clog2(MAX_DIM)-1:0]   nbr_max_row_i,
  output logic                         seen_o,
  output logic [$clog2(MAX_DIM)-1:0]   min_col_o,
  output logic [$clog2(MAX_DIM)-1:0]   max_col_o,
  output logic [$clog2(MAX_DIM)-1:0]   min_row_o,
  output logic [$clog2(MAX_DIM)-1:0]   max_row_o
);

  localparam int CW = $clog2(MAX_DIM);
  localparam logic [CW-1:0] COORD_TOP = CW'(MAX_DIM - 1);

  pbb_pkg::pix_ctrl_t          ctrl_r;
  logic [pbb_pkg::LABEL_W-1:0] label_r;
  logic [CW-1:0]               col_r, row_r;

  logic          seen_r, seen_nxt;
  logic [CW-1:0] min_col_r, min_col_nxt, max_col_r, max_col_nxt;
  logic [CW-1:0] min_row_r, min_row_nxt, max_row_r, max_row_nxt;
  logic          hit;

  assign hit = ctrl_i.valid && (label_i == pbb_pkg::LABEL_W'(CLASS_ID));

  always_comb begin
    seen_nxt    = seen_r;
    min_col_nxt = min_col_r;
    max_col_nxt = max_col_r;
    min_row_nxt = min_row_r;
    max_row_nxt = max_row_r;
    if (shift_i) begin
      seen_nxt    = nbr_seen_i;
      min_col_nxt = nbr_min_col_i;
      max_col_nxt = nbr_max_col_i;
      min_row_nxt = nbr_min_row_i;
      max_row_nxt = nbr_max_row_i;
    end else if (hit) begin
      seen_nxt = 1'b1;
      if (col_i < min_col_r) min_col_nxt = col_i;
      if (col_i > max_col_r) max_col_nxt = col_i;
      if (row_i < min_row_r) min_row_nxt = row_i;
      if (row_i > max_row_r) max_row_nxt = row_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r    <= '0;
      seen_r    <= 1'b0;
      min_col_r <= COORD_TOP;
      max_col_r <= '0;
      min_row_r <= COORD_TOP;
      max_row_r <= '0;
    end else begin
      ctrl_r    <= ctrl_i;
      seen_r    <= seen_nxt;
      min_col_r <= min_col_nxt;
      max_col_r <= max_col_nxt;
      min_row_r <= min_row_nxt;
      max_row_r <= max_row_nxt;
    end
  end

  // pixel payload, no reset
  always_ff @(posedge clk) begin
    label_r <= label_i;
    col_r   <= col_i;
    row_r   <= row_i;
  end

  assign ctrl_o    = ctrl_r;
  assign label_o   = label_r;
  assign col_o     = col_r;
  assign row_o     = row_r;
  assign seen_o    = seen_r;
  assign min_col_o = min_col_r;
  assign max_col_o = max_col_r;
  assign min_row_o = min_row_r;
  assign max_row_o = max_row_r;

endmodule

// ===== hw/rtl/per_label_bounding_box.sv =====
// Channel    | Ports                                          | Handshake
// -----------+------------------------------------------------+------------------------------
// pixel in   | in_label, in_end_of_frame                      | start & !busy
// box out    | out_class_index, out_found, out_box_x/y,       | out_valid, one cycle each,
//            | out_box_width, out_box_height, out_last        | no backpressure
// config     | cfg_frame_width                                | cfg_we
//
// One pixel per cycle while no frame is closing. A pixel travels down the
// chain of NUM_CLASSES cells one cell per cycle; busy stays low between frames.
// The end-of-frame request raises busy through the chain flush and then the
// result drain. Results come back to back, class 1 first, out_last on the final.
// Reset (rst_n low, synchronous) clears every cell, the counters and the width
// register to 640; the receiver cannot stall, so results are never held.
module per_label_bounding_box #(
  parameter int NUM_CLASSES = pbb_pkg::NUM_CLASSES_DEF,
  parameter int MAX_DIM     = pbb_pkg::MAX_DIM_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  output logic                                     busy,
  input  logic [pbb_pkg::LABEL_W-1:0]              in_label,
  input  logic                                     in_end_of_frame,
  output logic                                     out_valid,
  output logic [pbb_pkg::CLASS_IDX_W-1:0]          out_class_index,
  output logic                                     out_found,
  output logic signed [pbb_pkg::POS_W-1:0]         out_box_x,
  output logic signed [pbb_pkg::POS_W-1:0]         out_box_y,
  output logic signed [pbb_pkg::SIZE_W-1:0]        out_box_width,
  output logic signed [pbb_pkg::SIZE_W-1:0]        out_box_height,
  output logic                                     out_last,
  input  logic                                     cfg_we,
  input  logic [pbb_pkg::FRAME_W-1:0]              cfg_frame_width
);

  localparam int CW    = $clog2(MAX_DIM);
  localparam int CNT_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam logic [CW-1:0]    COORD_TOP = CW'(MAX_DIM - 1);
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(NUM_CLASSES - 1);

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [pbb_pkg::FRAME_W-1:0] frame_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r <= pbb_pkg::FRAME_WIDTH_RESET;
    end else if (cfg_we) begin
      frame_width_r <= cfg_frame_width;
    end
  end

  // Zero acts as one, anything past MAX_DIM acts as MAX_DIM.
  logic [31:0] eff_width;

  always_comb begin
    eff_width = 32'(frame_width_r);
    if (frame_width_r == '0) begin
      eff_width = 32'd1;
    end else if (32'(frame_width_r) > 32'(MAX_DIM)) begin
      eff_width = 32'(MAX_DIM);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  pbb_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;
  logic             shift_en;
  logic             tail_eof;

  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pbb_pkg::ST_IDLE: begin
        if (accept && in_end_of_frame) state_nxt = pbb_pkg::ST_FLUSH;
      end
      pbb_pkg::ST_FLUSH: begin
        // last cell has taken the end-of-frame pixel
        if (tail_eof) state_nxt = pbb_pkg::ST_DRAIN;
      end
      pbb_pkg::ST_DRAIN: begin
        if (cnt_r == CNT_LAST) state_nxt = pbb_pkg::ST_IDLE;
      end
      default: state_nxt = pbb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy     = 1'b1;
    shift_en = 1'b0;
    case (state_r)
      pbb_pkg::ST_IDLE:  busy = 1'b0;
      pbb_pkg::ST_FLUSH: busy = 1'b1;
      pbb_pkg::ST_DRAIN: shift_en = 1'b1;
      default:           busy = 1'b1;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (shift_en) begin
      cnt_nxt = (cnt_r == CNT_LAST) ? '0 : cnt_r + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Raster position
  // ---------------------------------------------------------------------------
  logic [CW-1:0] col_r, col_nxt, row_r, row_nxt;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (in_end_of_frame) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (32'(col_r) >= eff_width - 32'd1) begin
        col_nxt = '0;
        if (row_r < COORD_TOP) row_nxt = row_r + 1'b1;  // saturates on the last row
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pbb_pkg::ST_IDLE;
      cnt_r   <= '0;
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Cell chain: pixels flow from cell 0 upward, boxes drain toward cell 0.
  // ---------------------------------------------------------------------------
  pbb_pkg::pix_ctrl_t          pc   [NUM_CLASSES+1];
  logic [pbb_pkg::LABEL_W-1:0] plab [NUM_CLASSES+1];
  logic [CW-1:0]               pcol [NUM_CLASSES+1];
  logic [CW-1:0]               prow [NUM_CLASSES+1];

  logic          bseen [NUM_CLASSES+1];
  logic [CW-1:0] bminc [NUM_CLASSES+1];
  logic [CW-1:0] bmaxc [NUM_CLASSES+1];
  logic [CW-1:0] bminr [NUM_CLASSES+1];
  logic [CW-1:0] bmaxr [NUM_CLASSES+1];

  assign pc[0].valid = accept;
  assign pc[0].eof   = in_end_of_frame;
  assign plab[0]     = in_label;
  assign pcol[0]     = col_r;
  assign prow[0]     = row_r;

  // cleared box enters behind the drain, so the store is empty afterward
  assign bseen[NUM_CLASSES] = 1'b0;
  assign bminc[NUM_CLASSES] = COORD_TOP;
  assign bmaxc[NUM_CLASSES] = '0;
  assign bminr[NUM_CLASSES] = COORD_TOP;
  assign bmaxr[NUM_CLASSES] = '0;

  assign tail_eof = pc[NUM_CLASSES].valid && pc[NUM_CLASSES].eof;

  for (genvar k = 0; k < NUM_CLASSES; k++) begin : g_cell
    pbb_cell #(
      .CLASS_ID (k + 1),
      .MAX_DIM  (MAX_DIM)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctrl_i        (pc[k]),
      .label_i       (plab[k]),
      .col_i         (pcol[k]),
      .row_i         (prow[k]),
      .ctrl_o        (pc[k+1]),
      .label_o       (plab[k+1]),
      .col_o         (pcol[k+1]),
      .row_o         (prow[k+1]),
      .shift_i       (shift_en),
      .nbr_seen_i    (bseen[k+1]),
      .nbr_min_col_i (bminc[k+1]),
      .nbr_max_col_i (bmaxc[k+1]),
      .nbr_min_row_i (bminr[k+1]),
      .nbr_max_row_i (bmaxr[k+1]),
      .seen_o        (bseen[k]),
      .min_col_o     (bminc[k]),
      .max_col_o     (bmaxc[k]),
      .min_row_o     (bminr[k]),
      .max_row_o     (bmaxr[k])
    );
  end

  // ---------------------------------------------------------------------------
  // Result formatting from the head cell, registered
  // ---------------------------------------------------------------------------
  logic [31:0] x_full, y_full, w_full, h_full, idx_full;

  always_comb begin
    idx_full = 32'(cnt_r) + 32'd1;
    if (bseen[0]) begin
      x_full = 32'(bminc[0]);
      y_full = 32'(bminr[0]);
      w_full = 32'(bmaxc[0]) - 32'(bminc[0]) + 32'd1;
      h_full = 32'(bmaxr[0]) - 32'(bminr[0]) + 32'd1;
    end else begin
      // absent class reports -1 in x, y, width and height
      x_full = '1;
      y_full = '1;
      w_full = '1;
      h_full = '1;
    end
  end

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= shift_en;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      out_class_index <= idx_full[pbb_pkg::CLASS_IDX_W-1:0];
      out_found       <= bseen[0];
      out_box_x       <= x_full[pbb_pkg::POS_W-1:0];
      out_box_y       <= y_full[pbb_pkg::POS_W-1:0];
      out_box_width   <= w_full[pbb_pkg::SIZE_W-1:0];
      out_box_height  <= h_full[pbb_pkg::SIZE_W-1:0];
      out_last        <= (cnt_r == CNT_LAST);
    end
  end

  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `include "assert_macros.svh"

  `PBB_ASSERT_IMP(a_out_from_drain, out_valid, $past(busy))
  `PBB_ASSERT_NXT(a_eof_closes_frame, start && !busy && in_end_of_frame, busy)
  `PBB_ASSERT_NXT(a_results_back_to_back, out_valid && !out_last, out_valid)
  `PBB_ASSERT_IMP(a_last_frees_input, out_valid && out_last, !busy)
  `PBB_ASSERT_IMP(a_last_is_top_class, out_valid && out_last,
                  out_class_index == pbb_pkg::CLASS_IDX_W'(NUM_CLASSES))

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pbb_pkg::*;

  localparam int NCLS          = NUM_CLASSES_DEF;
  localparam int MAXD          = MAX_DIM_DEF;
  // Frame close: chain flush plus result drain, plus margin.
  localparam int SETTLE_CYCLES = 2 * NCLS + 6;
  // Longest quiet stretch in a correct run is well under the watchdog limit.
  localparam int WATCHDOG      = 2000;
  localparam int RANDOM_PIXELS = 190;
  localparam int SHOW_MAX      = 10;

  // One box result as it appears on the out_ ports.
  typedef struct packed {
    logic [CLASS_IDX_W-1:0] cls;
    logic                   found;
    logic [POS_W-1:0]       x;
    logic [POS_W-1:0]       y;
    logic [SIZE_W-1:0]      w;
    logic [SIZE_W-1:0]      h;
    logic                   last;
  } box_t;

  // Hand-written frame outcome: one class present, every other class absent.
  // cls = 0 means nothing was present.
  typedef struct {
    int cls;
    int x;
    int y;
    int w;
    int h;
  } typed_box_t;

  typedef enum logic {R_PIX, R_CFG} row_kind_t;

  // Directed script row. R_CFG: value is the new frame width.
  // R_PIX: value is the label; typed rows carry their expected box.
  typedef struct {
    row_kind_t kind;
    int        value;
    bit        eof;
    bit        typed;
    int        cls;
    int        x;
    int        y;
    int        w;
    int        h;
  } dir_row_t;

  logic                   clk             = 1'b0;
  logic                   rst_n           = 1'b0;
  logic                   start           = 1'b0;
  logic                   busy;
  logic [LABEL_W-1:0]     in_label        = '0;
  logic                   in_end_of_frame = 1'b0;
  logic                   out_valid;
  logic [CLASS_IDX_W-1:0] out_class_index;
  logic                   out_found;
  logic signed [POS_W-1:0]  out_box_x;
  logic signed [POS_W-1:0]  out_box_y;
  logic signed [SIZE_W-1:0] out_box_width;
  logic signed [SIZE_W-1:0] out_box_height;
  logic                   out_last;
  logic                   cfg_we          = 1'b0;
  logic [FRAME_W-1:0]     cfg_frame_width = '0;

  per_label_bounding_box u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_label        (in_label),
    .in_end_of_frame (in_end_of_frame),
    .out_valid       (out_valid),
    .out_class_index (out_class_index),
    .out_found       (out_found),
    .out_box_x       (out_box_x),
    .out_box_y       (out_box_y),
    .out_box_width   (out_box_width),
    .out_box_height  (out_box_height),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_frame_width (cfg_frame_width)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Box predictor: own copy of the per-class extents, the raster position and
  // the width register. Updated in the monitor: the width at each cfg_we, the rest at every accepted request.
  // ---------------------------------------------------------------------------
  logic [11:0]        col_lo [NCLS];
  logic [11:0]        col_hi [NCLS];
  logic [11:0]        row_lo [NCLS];
  logic [11:0]        row_hi [NCLS];
  bit                 seen   [NCLS];
  logic [11:0]        col_pos;
  logic [11:0]        row_pos;
  logic [FRAME_W-1:0] width_reg;

  box_t       pending_boxes [$];  // boxes still owed by the block, oldest first
  typed_box_t typed_boxes   [$];  // hand-written outcome for the next frame close

  int  fails       = 0;
  int  shown       = 0;
  int  idle_cycles = 0;
  bit  calm        = 1'b0;        // no sender gaps while set

  task automatic clear_extents();
    for (int c = 0; c < NCLS; c++) begin
      col_lo[c] = '1;
      col_hi[c] = '0;
      row_lo[c] = '1;
      row_hi[c] = '0;
      seen[c]   = 1'b0;
    end
    col_pos = '0;
    row_pos = '0;
  endtask

  task automatic track_pixel(input logic [LABEL_W-1:0] lbl, input logic eof);
    int         w;
    int         k;
    bit         use_typed;
    typed_box_t tb_box;
    box_t       b;
    // Width 0 behaves as 1, anything past MAXD is clamped.
    if (width_reg == 0)
      w = 1;
    else if (int'(width_reg) > MAXD)
      w = MAXD;
    else
      w = int'(width_reg);

    if (lbl >= 1 && lbl <= NCLS) begin
      k = int'(lbl) - 1;
      if (col_pos < col_lo[k]) col_lo[k] = col_pos;
      if (col_pos > col_hi[k]) col_hi[k] = col_pos;
      if (row_pos < row_lo[k]) row_lo[k] = row_pos;
      if (row_pos > row_hi[k]) row_hi[k] = row_pos;
      seen[k] = 1'b1;
    end

    // A column at or past the last one (width may have shrunk) wraps the row.
    // Row saturates at MAXD-1.
    if (int'(col_pos) >= w - 1) begin
      col_pos = '0;
      if (int'(row_pos) < MAXD - 1) row_pos = row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end

    if (eof) begin
      use_typed = (typed_boxes.size() > 0);
      if (use_typed) tb_box = typed_boxes.pop_front();
      for (int c = 0; c < NCLS; c++) begin
        b.cls  = CLASS_IDX_W'(c + 1);
        b.last = (c == NCLS - 1);
        if (use_typed ? (tb_box.cls == c + 1) : seen[c]) begin
          b.found = 1'b1;
          if (use_typed) begin
            b.x = POS_W'(tb_box.x);
            b.y = POS_W'(tb_box.y);
            b.w = SIZE_W'(tb_box.w);
            b.h = SIZE_W'(tb_box.h);
          end else begin
            b.x = POS_W'(col_lo[c]);
            b.y = POS_W'(row_lo[c]);
            b.w = SIZE_W'(int'(col_hi[c]) - int'(col_lo[c]) + 1);
            b.h = SIZE_W'(int'(row_hi[c]) - int'(row_lo[c]) + 1);
          end
        end else begin
          // Absent class: -1 in x, y, w and h.
          b.found = 1'b0;
          b.x     = '1;
          b.y     = '1;
          b.w     = '1;
          b.h     = '1;
        end
        pending_boxes = {pending_boxes, b};
      end
      clear_extents();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: samples at the rising edge, before any NBA of this step lands.
  // Checks results first, then books the request accepted at the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    box_t got;
    box_t want;
    if (!rst_n) begin
      width_reg = FRAME_WIDTH_RESET;
      clear_extents();
    end else begin
      if (out_valid) begin
        got = {out_class_index, out_found, out_box_x, out_box_y,
               out_box_width, out_box_height, out_last};
        if (pending_boxes.size() == 0) begin
          fails++;
          if (shown < SHOW_MAX) begin
            shown++;
            $display("unexpected box: cls=%0d found=%0d x=%0d y=%0d w=%0d h=%0d last=%0d",
                     got.cls, got.found, $signed(got.x), $signed(got.y),
                     $signed(got.w), $signed(got.h), got.last);
          end
        end else begin
          want = pending_boxes.pop_front();
          if (got !== want) begin
            fails++;
            if (shown < SHOW_MAX) begin
              shown++;
              $display("box mismatch exp: cls=%0d found=%0d x=%0d y=%0d w=%0d h=%0d last=%0d",
                       want.cls, want.found, $signed(want.x), $signed(want.y),
                       $signed(want.w), $signed(want.h), want.last);
              $display("             got: cls=%0d found=%0d x=%0d y=%0d w=%0d h=%0d last=%0d",
                       got.cls, got.found, $signed(got.x), $signed(got.y),
                       $signed(got.w), $signed(got.h), got.last);
            end
          end
        end
      end
      if (cfg_we) width_reg = cfg_frame_width;
      if (start && !busy) track_pixel(in_label, in_end_of_frame);
    end

    // Watchdog: any request or result resets the count.
    if ((start && !busy) || out_valid)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog: no traffic for %0d cycles", WATCHDOG);
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Mostly back to back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm)   return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [LABEL_W-1:0] pick_label();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return '0;
    if (r < 85) return LABEL_W'($urandom_range(1, NCLS));
    return LABEL_W'($urandom_range(NCLS + 1, 255));
  endfunction

  // Small widths keep frames spanning several rows; some picks hit the clamps, some are random.
  function automatic logic [FRAME_W-1:0] pick_width();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return FRAME_W'($urandom_range(1, 8));
    if (r < 70) return FRAME_W'($urandom_range(9, 64));
    if (r < 80) return FRAME_W'($urandom_range(0, 1));
    if (r < 90) return FRAME_W'($urandom_range(MAXD, 8191));
    return FRAME_W'($urandom_range(0, 8191));
  endfunction

  // Issue one pixel request and return at the edge that accepts it. start is
  // left high so a back-to-back request needs no second NBA in this step.
  task automatic push_pixel(input logic [LABEL_W-1:0] lbl, input logic eof);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_label        <= lbl;
    in_end_of_frame <= eof;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Stop sending, wait for every owed box, then let the chain empty out.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_boxes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(input logic [FRAME_W-1:0] v);
    wait_drained();
    cfg_we          <= 1'b1;
    cfg_frame_width <= v;
    @(posedge clk);
    cfg_we          <= 1'b0;
  endtask

  task automatic expect_typed(input int cls, input int x, input int y,
                              input int w, input int h);
    typed_box_t t;
    t.cls = cls;
    t.x   = x;
    t.y   = y;
    t.w   = w;
    t.h   = h;
    typed_boxes = {typed_boxes, t};
  endtask

  // ---------------------------------------------------------------------------
  // Directed script. Width starts at the reset value 640.
  // ---------------------------------------------------------------------------
  dir_row_t steps [$] = '{
    // empty frame straight out of reset: all classes absent
    '{R_PIX,   0, 1'b1, 1'b1,  0, 0, 0, 0, 0},
    // highest class, single pixel at the origin
    '{R_PIX,  13, 1'b1, 1'b1, 13, 0, 0, 1, 1},
    // out-of-range labels are skipped but still advance the column
    '{R_PIX, 255, 1'b0, 1'b0,  0, 0, 0, 0, 0},
    '{R_PIX,  14, 1'b0, 1'b0,  0, 0, 0, 0, 0},
    '{R_PIX,   1, 1'b1, 1'b1,  1, 2, 0, 1, 1},
    // zero width behaves as one pixel per row
    '{R_CFG,   0, 1'b0, 1'b0,  0, 0, 0, 0, 0},
    '{R_PIX,   5, 1'b0, 1'b0,  0, 0, 0, 0, 0},
    '{R_PIX,   0, 1'b0, 1'b0,  0, 0, 0, 0, 0},
    '{R_PIX,   5, 1'b1, 1'b1,  5, 0, 0, 1, 3},
    // small width, several classes, predictor checked
    '{R_CFG,   3, 1'b0, 1'b0,  0, 0, 0, 0, 0},
    '{R_PIX,   2, 1'b0, 1'b0,  0, 0, 0, 0, 0},
    '{R_PIX,   7, 1'b0, 1'b0,  0, 0, 0, 0, 0},
    '{R_PIX,   2, 1'b0, 1'b0,  0, 0, 0, 0, 0},
    '{R_PIX,  12, 1'b0, 1'b0,  0, 0, 0, 0, 0},
    '{R_PIX,   2, 1'b1, 1'b0,  0, 0, 0, 0, 0},
    // oversized width clamps
    '{R_CFG, 8191, 1'b0, 1'b0, 0, 0, 0, 0, 0},
    '{R_PIX, 128, 1'b0, 1'b0,  0, 0, 0, 0, 0},
    '{R_PIX,   9, 1'b1, 1'b1,  9, 1, 0, 1, 1},
    // shrink the width mid-frame while the column is past the new last column
    '{R_CFG,   4, 1'b0, 1'b0,  0, 0, 0, 0, 0},
    '{R_PIX,   3, 1'b0, 1'b0,  0, 0, 0, 0, 0},
    '{R_PIX,   0, 1'b0, 1'b0,  0, 0, 0, 0, 0},
    '{R_PIX,   0, 1'b0, 1'b0,  0, 0, 0, 0, 0},
    '{R_CFG,   2, 1'b0, 1'b0,  0, 0, 0, 0, 0},
    '{R_PIX,   3, 1'b0, 1'b0,  0, 0, 0, 0, 0},
    '{R_PIX,   3, 1'b1, 1'b0,  0, 0, 0, 0, 0},
    '{R_CFG, 4097, 1'b0, 1'b0, 0, 0, 0, 0, 0},
    '{R_PIX,  11, 1'b1, 1'b1, 11, 0, 0, 1, 1}
  };

  initial begin
    int sent;
    int flen;
    int split;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (steps[i]) begin
      if (steps[i].kind == R_CFG) begin
        write_width(FRAME_W'(steps[i].value));
      end else begin
        if (steps[i].typed)
          expect_typed(steps[i].cls, steps[i].x, steps[i].y, steps[i].w, steps[i].h);
        push_pixel(LABEL_W'(steps[i].value), steps[i].eof);
      end
    end

    // Random frames: random widths, occasional width change mid-frame,
    // occasional full drain, bursty and gappy stretches.
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) write_width(pick_width());
      flen  = $urandom_range(1, 24);
      split = ($urandom_range(0, 6) == 0) ? $urandom_range(1, flen) : 0;
      for (int j = 0; j < flen; j++) begin
        if (split != 0 && j == split) write_width(pick_width());
        push_pixel(pick_label(), j == flen - 1);
      end
      sent += flen;
      if ($urandom_range(0, 9) == 0) wait_drained();
    end

    // Drain and let any stray result show up.
    wait_drained();
    if (fails == 0 && pending_boxes.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
